@@ hw/rtl/prcb_pkg.sv @@
// Shared types and constants of the page channel router and batcher
`default_nettype none

package prcb_pkg;

  // storage sizes
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned MaxBatch    = 128;

  // field widths
  localparam int unsigned ChW     = 3;
  localparam int unsigned SlotW   = 7;
  localparam int unsigned CountW  = 8;
  localparam int unsigned RegionW = 16;
  localparam int unsigned OffsW   = 48;
  localparam int unsigned TotalW  = 4;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;

  // hash multiplier and hot threshold
  localparam logic [31:0] HashMul  = 32'd2654435761;
  localparam logic [1:0]  HotLevel = 2'd2;

  typedef logic [ChW-1:0]     ch_t;
  typedef logic [SlotW-1:0]   slot_t;
  typedef logic [CountW-1:0]  count_t;
  typedef logic [RegionW-1:0] region_t;
  typedef logic [OffsW-1:0]   offs_t;

  // input actions
  typedef enum logic [0:0] {
    ACT_PAGE = 1'b0,
    ACT_SYNC = 1'b1
  } action_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAGE  = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_SYNC  = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNEL_TOTAL = 2'd0,
    REG_DELTA_MODE    = 2'd1,
    REG_BATCH_PAGES   = 2'd2
  } reg_idx_e;

endpackage

`default_nettype wire

@@ hw/rtl/prcb_if.sv @@
// Handshake channels for page items and result items
`default_nettype none

interface prcb_page_if
  import prcb_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    action;
  region_t region_id;
  offs_t   page_offset;
  logic [1:0] hotness;

  modport source (output valid, action, region_id, page_offset, hotness, input ready);
  modport sink   (input valid, action, region_id, page_offset, hotness, output ready);
endinterface

interface prcb_res_if
  import prcb_pkg::*;
();
  logic    valid;
  logic    ready;
  logic [1:0] kind;
  ch_t     channel;
  slot_t   slot;
  offs_t   out_offset;
  region_t flush_region;
  count_t  flush_count;
  logic    last;

  modport source (output valid, kind, channel, slot, out_offset, flush_region, flush_count,
                  last, input ready);
  modport sink   (input valid, kind, channel, slot, out_offset, flush_region, flush_count,
                  last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/page_channel_router_batcher_unit.sv @@
// Top level: page router to send channels with per-channel batching
//
// Takes one item at a time (page_i.ready is high only when idle) and emits its
// results one by one through a single output register, which may still hold
// a result while the next item is taken. A sync item walks all 8 channels one
// per cycle while the output is free or the channel is empty, flushing each
// non-empty one, then gives the done marker. A page item that needs a hash
// makes two passes of a shared 24x32 multiplier and one 64-bit add, then a
// shared remainder unit folds all 64 hash bits, 8 hash bits per cycle, then come
// the routing step, which may emit a flush first, and the accept. Pages
// that need no hash (single channel, hot page in delta mode, pool of one)
// go straight to routing. The user writes configuration through cfg_we_i/
// cfg_idx_i/cfg_data_i only while idle (unenforced); counts and region tags reset to zero.
`default_nettype none

module page_channel_router_batcher_unit
  import prcb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  prcb_page_if.sink               page_i,
  prcb_res_if.source              res_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL_LO = 9'b000000010,
    S_MUL_HI = 9'b000000100,
    S_ADD    = 9'b000001000,
    S_MOD    = 9'b000010000,
    S_ROUTE  = 9'b000100000,
    S_PUT    = 9'b001000000,
    S_SCAN   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [TotalW-1:0] chan_total_q;
  logic              delta_on_q;
  count_t            batch_pages_q;

  // per-channel state
  count_t  count_q  [MaxChannels];
  region_t region_q [MaxChannels];

  // item working registers
  region_t    in_region_q;
  offs_t      offs_q;
  ch_t        ch_q;
  logic       base_q;
  logic [3:0] pool_q;
  logic [55:0] prod_q;
  logic [63:0] hash_q;
  logic [2:0] rem_q;
  logic [2:0] step_q;
  ch_t        scan_q;

  // output register
  logic    out_valid_q;
  kind_e   out_kind_q;
  ch_t     out_ch_q;
  slot_t   out_slot_q;
  offs_t   out_offs_q;
  region_t out_region_q;
  count_t  out_count_q;
  logic    out_last_q;

  logic in_fire, out_free;
  assign page_i.ready = (state_q == S_IDLE);
  assign in_fire      = page_i.valid && page_i.ready;
  assign out_free     = !out_valid_q || res_o.ready;

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_kind_q;
  assign res_o.channel      = out_ch_q;
  assign res_o.slot         = out_slot_q;
  assign res_o.out_offset   = out_offs_q;
  assign res_o.flush_region = out_region_q;
  assign res_o.flush_count  = out_count_q;
  assign res_o.last         = out_last_q;

  // clamped configuration
  logic [3:0] total_c;
  count_t     limit_c;
  always_comb begin
    if (chan_total_q == '0) begin
      total_c = 4'd1;
    end else if (chan_total_q > TotalW'(MaxChannels)) begin
      total_c = 4'(MaxChannels);
    end else begin
      total_c = chan_total_q;
    end
    if (batch_pages_q == '0) begin
      limit_c = 8'd1;
    end else if (batch_pages_q > CountW'(MaxBatch)) begin
      limit_c = CountW'(MaxBatch);
    end else begin
      limit_c = batch_pages_q;
    end
  end

  // channel choice at accept: direct pick or hash pool
  logic       need_hash_c;
  ch_t        direct_ch_c;
  logic       base_c;
  logic [3:0] pool_c;
  always_comb begin
    need_hash_c = 1'b0;
    direct_ch_c = '0;
    base_c      = 1'b0;
    pool_c      = total_c;
    if (total_c > 4'd1) begin
      if (delta_on_q) begin
        base_c = 1'b1;
        pool_c = total_c - 4'd1;
      end
      if (delta_on_q && page_i.hotness >= HotLevel) begin
        direct_ch_c = '0;
      end else if (pool_c <= 4'd1) begin
        direct_ch_c = ChW'(base_c);
      end else begin
        need_hash_c = 1'b1;
      end
    end
  end

  // shared remainder unit: folds 8 hash bits into the running remainder
  logic [2:0] rem_c;
  always_comb begin
    logic [3:0] t;
    t     = '0;
    rem_c = rem_q;
    for (int b = 7; b >= 0; b--) begin
      t = {rem_c, hash_q[56 + b]};
      if (t >= pool_q) begin
        t = t - pool_q;
      end
      rem_c = t[2:0];
    end
  end

  // shared multiplier: low or high half of the offset times the hash constant
  logic [23:0] mul_a;
  logic [55:0] mul_p;
  assign mul_a = (state_q == S_MUL_LO) ? offs_q[23:0] : offs_q[47:24];
  assign mul_p = mul_a * HashMul;

  // per-channel read port
  ch_t     rd_idx;
  count_t  rd_count;
  region_t rd_region;
  assign rd_idx    = (state_q == S_SCAN) ? scan_q : ch_q;
  assign rd_count  = count_q[rd_idx];
  assign rd_region = region_q[rd_idx];

  // sequencer
  logic    emit;
  kind_e   e_kind;
  slot_t   e_slot;
  offs_t   e_offs;
  region_t e_region;
  count_t  e_count;
  logic    e_last;
  logic    cnt_we, reg_we;
  count_t  cnt_wd;
  always_comb begin
    state_d  = state_q;
    emit     = 1'b0;
    e_kind   = KIND_PAGE;
    e_slot   = '0;
    e_offs   = '0;
    e_region = '0;
    e_count  = '0;
    e_last   = 1'b0;
    cnt_we   = 1'b0;
    reg_we   = 1'b0;
    cnt_wd   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (page_i.action == ACT_SYNC) begin
            state_d = S_SCAN;
          end else if (need_hash_c) begin
            state_d = S_MUL_LO;
          end else begin
            state_d = S_ROUTE;
          end
        end
      end
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_ADD;
      S_ADD:    state_d = S_MOD;
      S_MOD: begin
        if (step_q == 3'd7) begin
          state_d = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (rd_count != '0 && (rd_region != in_region_q || rd_count >= limit_c)) begin
          if (out_free) begin
            emit     = 1'b1;
            e_kind   = KIND_FLUSH;
            e_region = rd_region;
            e_count  = rd_count;
            cnt_we   = 1'b1;
            cnt_wd   = '0;
            state_d  = S_PUT;
          end
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = KIND_PAGE;
          e_slot  = rd_count[SlotW-1:0];
          e_offs  = offs_q;
          e_last  = 1'b1;
          cnt_we  = 1'b1;
          cnt_wd  = rd_count + 8'd1;
          reg_we  = (rd_count == '0);
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_count == '0 || out_free) begin
          if (rd_count != '0) begin
            emit     = 1'b1;
            e_kind   = KIND_FLUSH;
            e_region = rd_region;
            e_count  = rd_count;
            cnt_we   = 1'b1;
            cnt_wd   = '0;
          end
          if (scan_q == ChW'(MaxChannels - 1)) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = KIND_SYNC;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      chan_total_q  <= 4'd2;
      delta_on_q    <= 1'b0;
      batch_pages_q <= 8'd128;
      out_valid_q   <= 1'b0;
      scan_q        <= '0;
      step_q        <= '0;
      for (int i = 0; i < MaxChannels; i++) begin
        count_q[i]  <= '0;
        region_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CHANNEL_TOTAL: chan_total_q  <= cfg_data_i[TotalW-1:0];
          REG_DELTA_MODE:    delta_on_q    <= cfg_data_i[0];
          REG_BATCH_PAGES:   batch_pages_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        scan_q <= '0;
      end else if (state_q == S_SCAN && (rd_count == '0 || out_free)) begin
        scan_q <= scan_q + ChW'(1);
      end
      if (state_q == S_ADD) begin
        step_q <= '0;
      end else if (state_q == S_MOD) begin
        step_q <= step_q + 3'd1;
      end
      if (cnt_we) begin
        count_q[rd_idx] <= cnt_wd;
      end
      if (reg_we) begin
        region_q[rd_idx] <= in_region_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_region_q <= page_i.region_id;
      offs_q      <= page_i.page_offset;
      ch_q        <= direct_ch_c;
      base_q      <= base_c;
      pool_q      <= pool_c;
    end
    unique case (state_q)
      S_MUL_LO: prod_q <= mul_p;
      S_MUL_HI: begin
        prod_q <= mul_p;
        hash_q <= {8'd0, prod_q};
      end
      S_ADD: begin
        hash_q <= hash_q + {prod_q[39:0], 24'd0};
        rem_q  <= '0;
      end
      S_MOD: begin
        hash_q <= {hash_q[55:0], 8'd0};
        rem_q  <= rem_c;
        if (step_q == 3'd7) begin
          ch_q <= ChW'(base_q) + rem_c;
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_kind_q   <= e_kind;
      out_ch_q     <= (e_kind == KIND_SYNC) ? ch_t'(0) : rd_idx;
      out_slot_q   <= e_slot;
      out_offs_q   <= e_offs;
      out_region_q <= e_region;
      out_count_q  <= e_count;
      out_last_q   <= e_last;
    end
  end

endmodule

`default_nettype wire
